>>> hw/rtl/tabs_pkg.sv
// Shared types and constants of the typed aligned bump suballocator.
// Used by the front, queue, back and top-level modules; depends on nothing.
package tabs_pkg;

    localparam int unsigned MEMORY_TYPES_DEF = 32;
    localparam int unsigned OFFSET_BITS_DEF  = 48;

    // Fixed field widths of the stream payload
    localparam int unsigned MASK_W   = 32;
    localparam int unsigned SIZE_W   = 48;
    localparam int unsigned ALIGN_W  = 5;
    localparam int unsigned TYPE_W   = 5;
    localparam int unsigned OUT_W    = 48;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned S_TDATA_W = 96;
    localparam int unsigned M_TDATA_W = 104;

    // Input tdata layout
    localparam int unsigned S_ALLOWED_LSB = 0;
    localparam int unsigned S_COH_BIT     = 32;
    localparam int unsigned S_VIS_BIT     = 33;
    localparam int unsigned S_SIZE_LSB    = 34;
    localparam int unsigned S_ALIGN_LSB   = 82;
    localparam int unsigned S_QTYPE_LSB   = 87;

    localparam int unsigned QUEUE_DEPTH = 2;

    // APB register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_COHERENT = 1'b0;
    localparam logic        REG_VISIBLE  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLACE = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NO_TYPE  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // What the back end has to do with a queued item
    typedef enum logic [2:0] {
        KIND_PLACE,
        KIND_NO_TYPE,
        KIND_QUERY,
        KIND_QUERY_BAD,
        KIND_CLEAR,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [TYPE_W-1:0]  type_idx;
        logic [ALIGN_W-1:0] align_log2;
        logic [SIZE_W-1:0]  item_size;
    } tabs_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tabs_qstat_t;

endpackage

>>> hw/rtl/typed_aligned_bump_suballocator_core.sv
// Top level of the typed aligned bump suballocator: APB registers and wiring.
// Depends on tabs_pkg, tabs_front, tabs_queue and tabs_back.
//
// Places items into per-memory-type regions by bumping a running end offset.
// A place request (command 0) drops the types lacking a demanded coherent or
// visible property, picks the lowest remaining type, rounds its end up to the
// alignment and returns type and offset; an empty result gives status 1 and
// an end past the offset range gives status 2 without storing. Query (1)
// reads one type's end, clear (2) zeroes all ends. Every item gives exactly
// one result. The block sustains one item per clock cycle while results are
// taken; an accepted item is first registered in the two-entry queue, and
// when the back end pops it, its combinational offset read, align, add and
// range check feed the result register, which is loaded as the new end is
// stored, so a following item always sees the updated end. A stalled result
// holds the back end, and two more items fill the queue before s_tready drops.
// The offsets are flip-flops cleared by reset at once; no clearing pass exists.
module typed_aligned_bump_suballocator_core
    import tabs_pkg::*;
#(
    parameter int unsigned MEMORY_TYPES = MEMORY_TYPES_DEF,
    parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // allowed_types[31:0], need_coherent[32], need_mappable[33], item_size[81:34],
    // align_log2[86:82], query_type[91:87], zero fill above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // chosen_type[4:0], placed_offset[52:5], type_total[100:53], zero fill above
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_tuser
);

    logic [MASK_W-1:0] coherent_mask_reg;
    logic [MASK_W-1:0] visible_mask_reg;
    logic              cfg_write;

    logic              push;
    logic              pop;
    tabs_item_t        push_item;
    tabs_item_t        head_item;
    tabs_qstat_t       qstat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coherent_mask_reg <= '0;
            visible_mask_reg  <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_COHERENT)
            begin
                coherent_mask_reg <= pwdata;
            end
            else
            begin
                visible_mask_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_VISIBLE) ? visible_mask_reg : coherent_mask_reg;

    tabs_front #(
        .MEMORY_TYPES (MEMORY_TYPES)
    ) u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .coherent_mask (coherent_mask_reg),
        .visible_mask  (visible_mask_reg),
        .qstat         (qstat),
        .push          (push),
        .push_item     (push_item)
    );

    tabs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    tabs_back #(
        .MEMORY_TYPES (MEMORY_TYPES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .qstat     (qstat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // A result only appears after the back end took an item from the queue
    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(pop))
        else $error("result appeared without a queued item");

    // Overflow results carry no placed offset
    a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_OVERFLOW) |-> (m_tdata[52:5] == '0))
        else $error("overflow result with a nonzero offset");

    // Pop only from a nonempty queue, and push only into a free slot
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty) && !(push && qstat.full && !pop))
        else $error("queue underflow or overflow");

endmodule

>>> hw/rtl/tabs_front.sv
// Front end: unpacks request items, filters memory types and classifies.
// Depends on tabs_pkg.
module tabs_front
    import tabs_pkg::*;
#(
    parameter int unsigned MEMORY_TYPES = MEMORY_TYPES_DEF
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // allowed_types[31:0], need_coherent[32], need_mappable[33], item_size[81:34],
    // align_log2[86:82], query_type[91:87], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic [MASK_W-1:0]    coherent_mask,
    input  logic [MASK_W-1:0]    visible_mask,
    input  tabs_qstat_t          qstat,
    output logic                 push,
    output tabs_item_t           push_item
);

    localparam int unsigned TW = (MEMORY_TYPES > 1) ? $clog2(MEMORY_TYPES) : 1;

    logic [MASK_W-1:0]       allowed;
    logic [TYPE_W-1:0]       query_type;
    logic [MEMORY_TYPES-1:0] candidates;
    logic [TW-1:0]           pick;
    logic                    query_ok;

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;

    assign allowed    = s_tdata[S_ALLOWED_LSB +: MASK_W];
    assign query_type = s_tdata[S_QTYPE_LSB +: TYPE_W];
    assign query_ok   = ({1'b0, query_type} < (TYPE_W+1)'(MEMORY_TYPES));

    // Drop types lacking a demanded property; bits of absent types fall away
    always_comb
    begin
        candidates = allowed[MEMORY_TYPES-1:0];
        if (s_tdata[S_COH_BIT])
        begin
            candidates = candidates & coherent_mask[MEMORY_TYPES-1:0];
        end
        if (s_tdata[S_VIS_BIT])
        begin
            candidates = candidates & visible_mask[MEMORY_TYPES-1:0];
        end
    end

    // Lowest remaining type wins
    always_comb
    begin
        pick = '0;
        for (int i = MEMORY_TYPES - 1; i >= 0; i--)
        begin
            if (candidates[i])
            begin
                pick = TW'(i);
            end
        end
    end

    always_comb
    begin
        push_item.align_log2 = s_tdata[S_ALIGN_LSB +: ALIGN_W];
        push_item.item_size  = s_tdata[S_SIZE_LSB +: SIZE_W];
        push_item.type_idx   = '0;
        unique case (s_tuser)
            CMD_PLACE:
            begin
                push_item.kind     = (candidates == '0) ? KIND_NO_TYPE : KIND_PLACE;
                push_item.type_idx = TYPE_W'(pick);
            end
            CMD_QUERY:
            begin
                push_item.kind     = query_ok ? KIND_QUERY : KIND_QUERY_BAD;
                push_item.type_idx = query_type;
            end
            CMD_CLEAR:
            begin
                push_item.kind = KIND_CLEAR;
            end
            default:
            begin
                push_item.kind = KIND_NOP;
            end
        endcase
    end

endmodule

>>> hw/rtl/tabs_queue.sv
// Short item queue between the front and back ends.
// Depends on tabs_pkg.
module tabs_queue
    import tabs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tabs_item_t  push_item,
    input  logic        pop,
    output tabs_item_t  head_item,
    output tabs_qstat_t qstat
);

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    tabs_item_t    slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head_item   = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/tabs_back.sv
// Back end: per-type running offsets, alignment, bump and result register.
// Depends on tabs_pkg.
module tabs_back
    import tabs_pkg::*;
#(
    parameter int unsigned MEMORY_TYPES = MEMORY_TYPES_DEF,
    parameter int unsigned OFFSET_BITS  = OFFSET_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tabs_item_t           head_item,
    input  tabs_qstat_t          qstat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // chosen_type[4:0], placed_offset[52:5], type_total[100:53], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_tuser
);

    localparam int unsigned TW = (MEMORY_TYPES > 1) ? $clog2(MEMORY_TYPES) : 1;
    // Alignment sum wide enough for a 31-bit mask plus a carry
    localparam int unsigned AW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
    // Bump sum wide enough for the size plus a carry
    localparam int unsigned SW = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;

    logic [OFFSET_BITS-1:0] ends_reg [MEMORY_TYPES];

    logic                   out_valid_reg;
    status_t                out_status_reg, out_status_next;
    logic [TYPE_W-1:0]      out_type_reg, out_type_next;
    logic [OUT_W-1:0]       out_offset_reg, out_offset_next;
    logic [OUT_W-1:0]       out_total_reg, out_total_next;

    logic [TW-1:0]          idx;
    logic [OFFSET_BITS-1:0] cur_end;
    logic [AW-1:0]          align_m1;
    logic [AW-1:0]          aligned;
    logic [SW-1:0]          new_end;
    logic                   range_ovf;
    logic                   do_write;
    logic                   do_clear;

    assign pop = !qstat.empty && (!out_valid_reg || m_tready);

    assign idx      = head_item.type_idx[TW-1:0];
    assign cur_end  = ends_reg[idx];
    assign align_m1 = (AW'(1) << head_item.align_log2) - AW'(1);
    assign aligned  = (AW'(cur_end) + align_m1) & ~align_m1;
    assign new_end  = SW'(aligned[OFFSET_BITS-1:0]) + SW'(head_item.item_size);
    // Either the rounded offset or the new end leaves the offset range
    assign range_ovf = (|aligned[AW-1:OFFSET_BITS]) || (|new_end[SW-1:OFFSET_BITS]);

    always_comb
    begin
        out_status_next = ST_DONE;
        out_type_next   = '0;
        out_offset_next = '0;
        out_total_next  = '0;
        do_write        = 1'b0;
        do_clear        = 1'b0;
        case (head_item.kind)
            KIND_PLACE:
            begin
                out_type_next = head_item.type_idx;
                if (range_ovf)
                begin
                    out_status_next = ST_OVERFLOW;
                    out_total_next  = OUT_W'(cur_end);
                end
                else
                begin
                    out_offset_next = OUT_W'(aligned[OFFSET_BITS-1:0]);
                    out_total_next  = OUT_W'(new_end[OFFSET_BITS-1:0]);
                    do_write        = 1'b1;
                end
            end
            KIND_NO_TYPE:
            begin
                out_status_next = ST_NO_TYPE;
            end
            KIND_QUERY:
            begin
                out_type_next  = head_item.type_idx;
                out_total_next = OUT_W'(cur_end);
            end
            KIND_QUERY_BAD:
            begin
                out_status_next = ST_NO_TYPE;
                out_type_next   = head_item.type_idx;
            end
            KIND_CLEAR:
            begin
                do_clear = 1'b1;
            end
            default:
            begin
                out_status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MEMORY_TYPES; i++)
            begin
                ends_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop && do_clear)
            begin
                for (int i = 0; i < MEMORY_TYPES; i++)
                begin
                    ends_reg[i] <= '0;
                end
            end
            else if (pop && do_write)
            begin
                ends_reg[idx] <= new_end[OFFSET_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_status_reg <= out_status_next;
            out_type_reg   <= out_type_next;
            out_offset_reg <= out_offset_next;
            out_total_reg  <= out_total_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(M_TDATA_W - TYPE_W - 2*OUT_W)'(0),
                       out_total_reg, out_offset_reg, out_type_reg};

endmodule
